// File: hdl/assert_macros.svh
// Assertion macros shared by the region table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("%m");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: hdl/rtm_pkg.sv
// Package for the region table: sizes, codes and entry type.
package rtm_pkg;
  localparam int TABLE_ENTRIES = 32;
  localparam int ADDR_BITS = 48;
  localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
  localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    logic  used;
    addr_t start;
    addr_t length;
    logic [2:0] prot;
  } entry_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [47:0] start_addr;
    logic [47:0] range_length;
    logic [2:0] prot;
    logic [47:0] lookup_addr;
  } req_t;

  typedef struct packed {
    logic status;
    logic found;
    logic [47:0] found_start;
    logic [47:0] found_length;
    logic [2:0] found_prot;
    logic writable;
  } rsp_t;
endpackage

// File: hdl/rtm_req_if.sv
// Valid-ready channel carrying one request word.
interface rtm_req_if import rtm_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rtm_rsp_if.sv
// Valid-ready channel carrying one response word.
interface rtm_rsp_if import rtm_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/region_table_merge_split_core.sv
// Region table top level: entry memory with a sequencer that scans it per word.
//
//   channel  dir  word
//   req      in   operation, start_addr, range_length, prot, lookup_addr
//   rsp      out  status, found, found_start, found_length, found_prot, writable
//
// Each scan reads one entry per cycle from a memory with one read and one write
// port and a registered read. Add takes up to two passes, remove one pass plus
// up to two per split, lookup one pass that stops at the first hit. A done state
// after the last pass sets the response valid. After reset a clearing pass
// writes every entry unused. A word is taken only when idle and the response
// register is empty.
`include "assert_macros.svh"
module region_table_merge_split_core import rtm_pkg::*; (
  input logic clk,
  input logic rst,
  rtm_req_if.sink req,
  rtm_rsp_if.source rsp
);
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_ADDM = 7'b0000100,
    S_ADDF = 7'b0001000, S_REM = 7'b0010000, S_LOOK = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd;
  state_t state;
  logic [CNT_BITS-1:0] cnt;      // address issued
  logic rd_ok;                   // rd holds entry at rd_idx
  logic [IDX_BITS-1:0] rd_idx;
  logic [IDX_BITS-1:0] raddr;
  logic resume;
  logic we;
  logic [IDX_BITS-1:0] waddr;
  entry_t wdata;
  req_t r;
  addr_t a_s, a_len, a_e;        // current add operands
  logic [2:0] a_pr;
  logic in_split;                // add run as part of a remove
  addr_t r_s, r_e;
  logic [IDX_BITS-1:0] rem_idx;
  rsp_t res;
  logic out_valid;

  // Entry ends and the remove cases.
  addr_t ee;
  logic ov, inside_r, both, left;
  assign ee = rd.start + rd.length;
  assign ov = rd.used && !(ee <= r_s || rd.start >= r_e);
  assign inside_r = rd.start >= r_s && ee <= r_e;
  assign both = rd.start < r_s && ee > r_e;
  assign left = rd.start < r_s;

  assign req.ready = state == S_IDLE && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data = res;

  logic last_rd;
  assign last_rd = rd_idx == IDX_BITS'(TABLE_ENTRIES - 1);

  // A split's add is finished and the remove scan picks up after the split entry.
  assign resume = (state == S_ADDM || state == S_ADDF) && rd_ok && in_split &&
                  (we || (state == S_ADDF && last_rd));

  // Read address for the entry that rd holds in the next cycle.
  always_comb begin
    raddr = cnt[IDX_BITS-1:0];
    if (state == S_IDLE) raddr = '0;
    else if (rd_ok && state == S_ADDM && !we && last_rd) raddr = '0;
    else if (rd_ok && state == S_REM && ov && both) raddr = '0;
    if (resume) raddr = rem_idx + 1'b1;
  end

  // A write to the entry being read is forwarded to the read data.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (we && waddr == raddr) rd <= wdata;
    else rd <= mem[raddr];
  end

  always_comb begin
    we = 1'b0;
    waddr = rd_idx;
    wdata = rd;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = cnt[IDX_BITS-1:0];
      wdata = '0;
    end else if (rd_ok) begin
      case (state)
        S_ADDM: if (rd.used && rd.prot == a_pr && ee == a_s) begin
          we = 1'b1;
          wdata.length = rd.length + a_len;
        end else if (rd.used && rd.prot == a_pr && a_e == rd.start) begin
          we = 1'b1;
          wdata.start = a_s;
          wdata.length = rd.length + a_len;
        end
        S_ADDF: if (!rd.used) begin
          we = 1'b1;
          wdata = '{used: 1'b1, start: a_s, length: a_len, prot: a_pr};
        end
        S_REM: if (ov) begin
          we = 1'b1;
          // A split entry also keeps only its left part here.
          if (inside_r) wdata.used = 1'b0;
          else if (left) wdata.length = r_s - rd.start;
          else begin
            wdata.start = r_e;
            wdata.length = ee - r_e;
          end
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      rd_ok <= 1'b0;
      out_valid <= 1'b0;
      in_split <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      rd_ok <= 1'b0;
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_BITS'(TABLE_ENTRIES - 1)) begin
            state <= S_IDLE;
            cnt <= '0;
          end
        end
        S_IDLE: if (req.valid && req.ready) begin
          r <= req.data;
          res <= '0;
          a_s <= req.data.start_addr;
          a_len <= req.data.range_length;
          a_e <= req.data.start_addr + req.data.range_length;
          a_pr <= req.data.prot;
          r_s <= req.data.start_addr;
          r_e <= req.data.start_addr + req.data.range_length;
          in_split <= 1'b0;
          cnt <= CNT_BITS'(1);
          rd_idx <= '0;
          rd_ok <= 1'b1;
          case (req.data.operation)
            OP_ADD: state <= S_ADDM;
            OP_REMOVE: state <= S_REM;
            OP_LOOKUP: state <= S_LOOK;
            default: state <= S_DONE;
          endcase
        end
        default: ;
      endcase
      if (state inside {S_ADDM, S_ADDF, S_REM, S_LOOK} && rd_ok) begin
        // Next read issues from cnt; advance sequentially.
        rd_idx <= cnt[IDX_BITS-1:0];
        cnt <= cnt + 1'b1;
        rd_ok <= !last_rd;
        case (state)
          S_ADDM: if (we) state <= in_split ? S_REM : S_DONE;
            else if (last_rd) begin
              state <= S_ADDF;
              cnt <= CNT_BITS'(1);
              rd_idx <= '0;
              rd_ok <= 1'b1;
            end
          S_ADDF: if (we) state <= in_split ? S_REM : S_DONE;
            else if (last_rd) begin
              if (!in_split) res.status <= 1'b1;
              state <= in_split ? S_REM : S_DONE;
            end
          S_REM: if (ov && both) begin
            // Keep left part now, then re-add the right part, then resume.
            rem_idx <= rd_idx;
            in_split <= 1'b1;
            a_s <= r_e;
            a_len <= ee - r_e;
            a_e <= ee;
            a_pr <= rd.prot;
            state <= S_ADDM;
            cnt <= CNT_BITS'(1);
            rd_idx <= '0;
            rd_ok <= 1'b1;
          end else if (last_rd) state <= S_DONE;
          S_LOOK: if (rd.used && r.lookup_addr >= rd.start && r.lookup_addr < ee) begin
            res.found <= 1'b1;
            res.found_start <= rd.start;
            res.found_length <= rd.length;
            res.found_prot <= rd.prot;
            res.writable <= rd.prot[1];
            state <= S_DONE;
            rd_ok <= 1'b0;
          end else if (last_rd) state <= S_DONE;
          default: ;
        endcase
      end
      // Resume remove after a split's add finishes.
      if (resume) begin
        in_split <= 1'b0;
        if (rem_idx == IDX_BITS'(TABLE_ENTRIES - 1)) begin
          state <= S_DONE;
          rd_ok <= 1'b0;
        end else begin
          rd_idx <= rem_idx + 1'b1;
          cnt <= CNT_BITS'(rem_idx) + CNT_BITS'(2);
          rd_ok <= 1'b1;
        end
      end
      if (state == S_DONE) begin
        out_valid <= 1'b1;
        state <= S_IDLE;
      end
    end
  end

  `ASSERT_IMPLIES(a_ready_idle, clk, rst, req.ready, state == S_IDLE)
  `ASSERT_NEXT(a_done_valid, clk, rst, state == S_DONE, out_valid)
  `ASSERT_IMPLIES(a_clear_no_take, clk, rst, state == S_CLEAR, !req.ready)
  `ASSERT_IMPLIES(a_status_add, clk, rst, out_valid && res.status, r.operation == OP_ADD)
endmodule
